FILE: src/pnfb_pkg.sv
// ----------------------------------------------------------------------------
// pnfb_pkg
// Shared types and constants of the packed 4-bit-per-pixel drawing engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pnfb_pkg;

  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int COLOR_W = 4;
  localparam int FUNC_W  = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [0:0] REG_WHITE_CODE = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_GET   = 2'd1,
    FUNC_FILL  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_INIT_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_MODIFY,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic setup;
    logic modify;
    logic clear;
    logic zero_fill;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  go;
    logic  fill_last;
    logic  clear_last;
    logic  out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: src/pnfb_ctrl.sv
// ----------------------------------------------------------------------------
// pnfb_ctrl
// Command sequencer: reset clear pass, pixel read-modify-write, rectangle
// walk, screen clear and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module pnfb_ctrl
  import pnfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        if (status.func == FUNC_CLEAR) begin
          state_next = ST_CLEAR;
        end else if (status.go) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (status.func == FUNC_FILL && !status.fill_last) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_INIT_CLEAR: begin
        cmd.clear     = 1'b1;
        cmd.zero_fill = 1'b1;
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_READ: begin
        cmd = '0;
      end
      ST_MODIFY: begin
        cmd.modify = 1'b1;
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/pnfb_datapath.sv
// ----------------------------------------------------------------------------
// pnfb_datapath
// Command registers, coordinate walkers, packed byte store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pnfb_datapath
  import pnfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  output dp_status_t              status,
  input  wire logic               s_tvalid,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [X_W-1:0]     in_x_start,
  input  wire logic [Y_W-1:0]     in_y_start,
  input  wire logic [X_W-1:0]     in_x_end,
  input  wire logic [Y_W-1:0]     in_y_end,
  input  wire logic [COLOR_W-1:0] in_color,
  input  wire logic [COLOR_W-1:0] white_code,
  input  wire logic               m_tready,
  output logic                    m_tvalid,
  output logic [COLOR_W-1:0]      pixel_value,
  output logic                    clipped
);

  localparam int ROW_BYTES = (SCREEN_WIDTH + 1) / 2;
  localparam int DEPTH     = ROW_BYTES * SCREEN_HEIGHT;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XBITS     = $clog2(SCREEN_WIDTH + 1);
  localparam int YBITS     = $clog2(SCREEN_HEIGHT + 1);
  localparam int XCW       = (XBITS > X_W) ? XBITS : X_W;
  localparam int YCW       = (YBITS > Y_W) ? YBITS : Y_W;

  localparam logic [XCW-1:0] SW_C      = XCW'(SCREEN_WIDTH);
  localparam logic [YCW-1:0] SH_C      = YCW'(SCREEN_HEIGHT);
  localparam logic [AW-1:0]  RB_C      = AW'(ROW_BYTES);
  localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);

  func_t              func;
  logic [X_W-1:0]     xs;
  logic [Y_W-1:0]     ys;
  logic [X_W-1:0]     xe;
  logic [Y_W-1:0]     ye;
  logic [COLOR_W-1:0] color;

  logic [XCW-1:0]     x;
  logic [YCW-1:0]     y;
  logic [XCW-1:0]     xl;
  logic [YCW-1:0]     yl;
  logic [AW-1:0]      row_base;
  logic [AW-1:0]      clr_addr;
  logic [COLOR_W-1:0] pix;
  logic               clip;

  logic [7:0]         mem [DEPTH];
  logic [7:0]         rd_data;

  logic [XCW-1:0]     xs_e;
  logic [YCW-1:0]     ys_e;
  logic [XCW-1:0]     xe_e;
  logic [YCW-1:0]     ye_e;
  logic [XCW-1:0]     xl_c;
  logic [YCW-1:0]     yl_c;
  logic               on_screen;
  logic               fill_go;
  logic               clip_c;
  logic [AW+YCW-1:0]  row_prod;
  logic [XCW-1:0]     x_inc;
  logic [YCW-1:0]     y_inc;
  logic               fill_last;
  logic [AW-1:0]      pix_addr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [7:0]         wdata;
  logic [7:0]         merged;

  assign xs_e = XCW'(xs);
  assign ys_e = YCW'(ys);
  assign xe_e = XCW'(xe);
  assign ye_e = YCW'(ye);
  assign xl_c = (xe_e > SW_C) ? SW_C : xe_e;
  assign yl_c = (ye_e > SH_C) ? SH_C : ye_e;

  assign on_screen = (xs_e < SW_C) && (ys_e < SH_C);
  assign fill_go   = (xs_e < xl_c) && (ys_e < yl_c);
  assign row_prod  = (AW + YCW)'(ys_e) * (AW + YCW)'(RB_C);

  always_comb begin
    case (func)
      FUNC_PUT:  clip_c = !on_screen;
      FUNC_GET:  clip_c = !on_screen;
      FUNC_FILL: clip_c = (xs < xe) && (ys < ye) && ((xe_e > SW_C) || (ye_e > SH_C));
      default:   clip_c = 1'b0;
    endcase
  end

  assign x_inc     = x + XCW'(1);
  assign y_inc     = y + YCW'(1);
  assign fill_last = (x_inc == xl) && (y_inc == yl);
  assign pix_addr  = row_base + AW'(x[XCW-1:1]);
  assign merged    = x[0] ? {rd_data[7:4], color} : {color, rd_data[3:0]};

  always_comb begin
    we    = 1'b0;
    waddr = pix_addr;
    wdata = merged;
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = cmd.zero_fill ? 8'h00 : {white_code, white_code};
    end else if (cmd.modify && func != FUNC_GET) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[pix_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.in_ready && s_tvalid) begin
      func  <= func_t'(in_func);
      xs    <= in_x_start;
      ys    <= in_y_start;
      xe    <= in_x_end;
      ye    <= in_y_end;
      color <= in_color;
    end
    if (cmd.setup) begin
      x        <= xs_e;
      y        <= ys_e;
      xl       <= xl_c;
      yl       <= yl_c;
      row_base <= row_prod[AW-1:0];
      clip     <= clip_c;
      pix      <= '0;
    end else if (cmd.modify) begin
      if (func == FUNC_GET) begin
        pix <= x[0] ? rd_data[3:0] : rd_data[7:4];
      end else if (func == FUNC_FILL && !fill_last) begin
        if (x_inc == xl) begin
          x        <= xs_e;
          y        <= y_inc;
          row_base <= row_base + RB_C;
        end else begin
          x <= x_inc;
        end
      end
    end
    if (cmd.out_load) begin
      pixel_value <= pix;
      clipped     <= clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= (clr_addr == LAST_ADDR) ? '0 : clr_addr + AW'(1);
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign status.func       = func;
  assign status.go         = (func == FUNC_FILL) ? fill_go : on_screen;
  assign status.fill_last  = fill_last;
  assign status.clear_last = (clr_addr == LAST_ADDR);
  assign status.out_free   = !m_tvalid || m_tready;

endmodule

`default_nettype wire

FILE: src/packed_nibble_framebuffer_draw_top.sv
// ----------------------------------------------------------------------------
// packed_nibble_framebuffer_draw_top
// Drawing engine over a framebuffer of two 4-bit pixels per byte.
//
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  one command word: func, coordinates, color
// m_*       out  m_tvalid/m_tready  one result word: pixel value, clip flag
// APB       in   psel/penable       white code register at byte address 0
//
// An on-screen put or get runs setup, one byte read and a modify step on the
// frame store before done; an off-screen one goes from setup straight to done.
// A fill reads and modifies each covered pixel in turn, and a clear writes the
// white code to every byte of the store. The result becomes valid in the same
// cycle as the engine is ready to accept the next word.
// After reset the whole store is cleared to zero before the first word is
// accepted.
// A new command word is accepted while the previous result waits in the
// output register; a stalled result holds the engine only at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_nibble_framebuffer_draw_top
  import pnfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // x_start[8:0], y_start[16:9], x_end[25:17], y_end[33:26], color[37:34]
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // func[1:0]
  input  wire logic [FUNC_W-1:0]      s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // pixel_value[3:0]
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // clipped[0]
  output logic                        m_tuser,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]       prdata,
  output logic                        pready
);

  dp_cmd_t            cmd;
  dp_status_t         status;
  logic [COLOR_W-1:0] white_code;
  logic [COLOR_W-1:0] pixel_value;
  logic               clipped;
  logic               reg_hit;

  assign reg_hit = (paddr[2:2] == REG_WHITE_CODE);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DATA_W'(white_code) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_code <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      white_code <= pwdata[COLOR_W-1:0];
    end
  end

  pnfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  pnfb_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .s_tvalid    (s_tvalid),
    .in_func     (s_tuser),
    .in_x_start  (s_tdata[8:0]),
    .in_y_start  (s_tdata[16:9]),
    .in_x_end    (s_tdata[25:17]),
    .in_y_end    (s_tdata[33:26]),
    .in_color    (s_tdata[37:34]),
    .white_code  (white_code),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .pixel_value (pixel_value),
    .clipped     (clipped)
  );

  assign s_tready = cmd.in_ready;
  assign m_tdata  = OUT_TDATA_W'(pixel_value);
  assign m_tuser  = clipped;

endmodule

`default_nettype wire

FILE: tb/sv/tb_packed_nibble_framebuffer_draw_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packed_nibble_framebuffer_draw_top
// Self-checking bench for the packed 4-bit-per-pixel drawing engine. It keeps
// its own copy of the frame store and uses it to predict every result word:
// puts, gets, fills with clipping and clears to the white code. The bench starts
// with a directed set of edge cases. Random command streams follow, with the
// sender idling and the receiver stalling in turn, and the white code is
// changed between phases.
// ----------------------------------------------------------------------------
module tb_packed_nibble_framebuffer_draw_top;
  import pnfb_pkg::*;

  localparam int SCREEN_W     = 320;
  localparam int SCREEN_H     = 240;
  localparam int ROW_BYTES    = (SCREEN_W + 1) / 2;
  localparam int STORE_BYTES  = ROW_BYTES * SCREEN_H;
  localparam int RANDOM_WORDS = 750;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 4000000;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_value;
    logic               clipped;
  } draw_result_t;

  class fb_scoreboard;
    bit [7:0]         frame [STORE_BYTES];
    bit [COLOR_W-1:0] white;
    draw_result_t     pending [$];
    int               errors;
    int               checked;
    int               issued [4];

    function new();
      foreach (frame[i]) frame[i] = 8'h00;
      foreach (issued[i]) issued[i] = 0;
      white   = '0;
      errors  = 0;
      checked = 0;
    endfunction

    task report(input string what);
      errors++;
      if (errors <= 50) $display("[%0t] ERROR: %s", $time, what);
    endtask

    function void put_px(input int unsigned x, input int unsigned y,
                         input bit [COLOR_W-1:0] c);
      int unsigned a;
      if (x >= SCREEN_W || y >= SCREEN_H) return;
      a = y * ROW_BYTES + x / 2;
      if (x % 2 == 0) frame[a][7:4] = c;
      else frame[a][3:0] = c;
    endfunction

    function bit [COLOR_W-1:0] get_px(input int unsigned x, input int unsigned y);
      int unsigned a;
      a = y * ROW_BYTES + x / 2;
      return (x % 2 == 0) ? frame[a][7:4] : frame[a][3:0];
    endfunction

    function void note_cmd(input logic [FUNC_W-1:0] fn,
                           input logic [IN_TDATA_W-1:0] d);
      int unsigned      xs, ys, xe, ye, xl, yl;
      bit [COLOR_W-1:0] col;
      draw_result_t     r;
      xs  = d[8:0];
      ys  = d[16:9];
      xe  = d[25:17];
      ye  = d[33:26];
      col = d[37:34];
      r   = '0;
      issued[fn]++;
      case (func_t'(fn))
        FUNC_PUT: begin
          if (xs >= SCREEN_W || ys >= SCREEN_H) r.clipped = 1'b1;
          else put_px(xs, ys, col);
        end
        FUNC_GET: begin
          if (xs >= SCREEN_W || ys >= SCREEN_H) r.clipped = 1'b1;
          else r.pixel_value = get_px(xs, ys);
        end
        FUNC_FILL: begin
          if (xs < xe && ys < ye) begin
            if (xe > SCREEN_W || ye > SCREEN_H) r.clipped = 1'b1;
            xl = (xe > SCREEN_W) ? SCREEN_W : xe;
            yl = (ye > SCREEN_H) ? SCREEN_H : ye;
            for (int unsigned y = ys; y < yl; y++)
              for (int unsigned x = xs; x < xl; x++)
                put_px(x, y, col);
          end
        end
        default: begin
          foreach (frame[i]) frame[i] = {white, white};
        end
      endcase
      pending.push_back(r);
    endfunction

    task check_result(input logic [OUT_TDATA_W-1:0] d, input logic clip);
      draw_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result word with no command outstanding (pixel %0h, clipped %0b)",
                         d[COLOR_W-1:0], clip));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (d[COLOR_W-1:0] !== want.pixel_value)
        report($sformatf("result %0d: pixel_value %0h, expected %0h",
                         checked, d[COLOR_W-1:0], want.pixel_value));
      if (clip !== want.clipped)
        report($sformatf("result %0d: clipped %0b, expected %0b",
                         checked, clip, want.clipped));
    endtask
  endclass

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata  = '0;
  logic [FUNC_W-1:0]     s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int          idle_pct    = 0;
  int          stall_pct   = 0;
  int          clears_left = 0;
  int          settings    = 0;
  int unsigned cycles      = 0;

  fb_scoreboard board = new();

  packed_nibble_framebuffer_draw_top #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, board.pending.size());
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
      if (s_tvalid && s_tready) board.note_cmd(s_tuser, s_tdata);
    end
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  task automatic send_cmd(input func_t fn, input int unsigned xs, input int unsigned ys,
                          input int unsigned xe, input int unsigned ye,
                          input int unsigned col);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {2'b00, col[3:0], ye[7:0], xe[8:0], ys[7:0], xs[8:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_white(input int unsigned code);
    logic [APB_DATA_W-1:0] word;
    word      = $urandom;
    word[3:0] = code[3:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * REG_WHITE_CODE);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.white = code[3:0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[COLOR_W-1:0] !== code[3:0])
      board.report($sformatf("white code reads back %0h, expected %0h",
                             prdata[COLOR_W-1:0], code[3:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    settings++;
  endtask

  function automatic int unsigned pick_x();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(23);
    if (r < 75) return $urandom_range(SCREEN_W - 1);
    if (r < 85) return $urandom_range(SCREEN_W - 1, SCREEN_W - 10);
    return $urandom_range(511);
  endfunction

  function automatic int unsigned pick_y();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(11);
    if (r < 75) return $urandom_range(SCREEN_H - 1);
    if (r < 85) return $urandom_range(SCREEN_H - 1, SCREEN_H - 8);
    return $urandom_range(255);
  endfunction

  task automatic random_cmd();
    int unsigned r, s, xs, ys, xe, ye;
    r  = $urandom_range(99);
    xs = pick_x();
    ys = pick_y();
    xe = $urandom_range(511);
    ye = $urandom_range(255);
    if (r < 2 && clears_left > 0) begin
      clears_left--;
      send_cmd(FUNC_CLEAR, $urandom_range(511), ys, xe, ye, $urandom_range(15));
    end else if (r < 38) begin
      send_cmd(FUNC_PUT, xs, ys, xe, ye, $urandom_range(15));
    end else if (r < 70) begin
      send_cmd(FUNC_GET, xs, ys, xe, ye, $urandom_range(15));
    end else begin
      s = $urandom_range(99);
      if (s < 8) begin
        // Horizontal thick line across the screen, sometimes past the right edge.
        xs = $urandom_range(3);
        xe = $urandom_range(SCREEN_W + 8, SCREEN_W - 4);
        ye = ys + $urandom_range(2, 1);
      end else if (s < 16) begin
        // Vertical thick line down the screen, sometimes past the bottom edge.
        xe = xs + $urandom_range(3, 1);
        ys = $urandom_range(3);
        ye = $urandom_range(255, SCREEN_H - 4);
      end else if (s < 26) begin
        xe = $urandom_range(xs);
        ye = ys + $urandom_range(4);
      end else begin
        xe = xs + $urandom_range(16);
        ye = ys + $urandom_range(8);
      end
      if (xe > 511) xe = 511;
      if (ye > 255) ye = 255;
      send_cmd(FUNC_FILL, xs, ys, xe, ye, $urandom_range(15));
    end
  endtask

  initial begin
    int unsigned codes [4];
    int          idle_tab [4];
    int          stall_tab [4];
    codes     = '{15, 0, $urandom_range(14, 1), $urandom_range(15)};
    idle_tab  = '{0, 52, 0, 27};
    stall_tab = '{0, 0, 52, 27};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_cmd(FUNC_PUT, 0, 0, 0, 0, 15);
    send_cmd(FUNC_PUT, 319, 239, 0, 0, 9);
    send_cmd(FUNC_PUT, 1, 0, 511, 255, 6);
    send_cmd(FUNC_PUT, 318, 239, 0, 0, 0);
    send_cmd(FUNC_GET, 0, 0, 0, 0, 0);
    send_cmd(FUNC_GET, 1, 0, 0, 0, 15);
    send_cmd(FUNC_GET, 319, 239, 0, 0, 0);
    send_cmd(FUNC_GET, 318, 239, 0, 0, 0);
    send_cmd(FUNC_PUT, 320, 0, 0, 0, 5);
    send_cmd(FUNC_PUT, 511, 255, 0, 0, 5);
    send_cmd(FUNC_GET, 0, 240, 0, 0, 0);
    send_cmd(FUNC_GET, 511, 255, 0, 0, 0);
    send_cmd(FUNC_FILL, 5, 5, 5, 9, 4);
    send_cmd(FUNC_FILL, 0, 10, 4, 2, 4);
    send_cmd(FUNC_FILL, 300, 2, 330, 5, 3);
    send_cmd(FUNC_FILL, 10, 230, 14, 255, 12);
    send_cmd(FUNC_GET, 310, 3, 0, 0, 0);
    send_cmd(FUNC_GET, 12, 239, 0, 0, 0);
    send_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0);
    send_cmd(FUNC_GET, 0, 0, 0, 0, 0);
    send_cmd(FUNC_FILL, 0, 0, 320, 240, 7);
    send_cmd(FUNC_GET, 200, 100, 0, 0, 0);
    send_cmd(FUNC_FILL, 400, 0, 480, 3, 2);
    send_cmd(FUNC_FILL, 319, 239, 511, 255, 1);
    send_cmd(FUNC_GET, 319, 239, 0, 0, 0);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_white(codes[p]);
      idle_pct    = idle_tab[p];
      stall_pct   = stall_tab[p];
      clears_left = 1;
      send_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0);
      repeat (RANDOM_WORDS / 4) random_cmd();
      drain();
    end

    if (board.pending.size() != 0)
      board.report($sformatf("%0d expected results never arrived", board.pending.size()));
    $display("Ran %0d puts, %0d gets, %0d fills and %0d clears over %0d white codes.",
             board.issued[FUNC_PUT], board.issued[FUNC_GET], board.issued[FUNC_FILL],
             board.issued[FUNC_CLEAR], settings);
    $display("Checked %0d result words in %0d cycles under four idle patterns.",
             board.checked, cycles);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/pnfb_pkg.sv
src/pnfb_ctrl.sv
src/pnfb_datapath.sv
src/packed_nibble_framebuffer_draw_top.sv
tb/sv/tb_packed_nibble_framebuffer_draw_top.sv
